/* sv/ipv4pp_pkg.sv */
// ---------------------------------------------------------------------------
// ipv4pp_pkg: shared types and constants for the IPv4 prefix text parser
// Parser state, result record and character codes used by the step logic
// and the top level.
// ---------------------------------------------------------------------------
package ipv4pp_pkg;

    // character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // limits
    localparam logic [8:0] OCTET_MAX    = 9'd255;
    localparam logic [8:0] PREFIX_MAX   = 9'd32;
    localparam logic [8:0] ACC_MAX      = 9'd511;
    localparam logic [2:0] LAST_OCTET   = 3'd3;
    localparam logic [2:0] PREFIX_FIELD = 3'd4;

    // running parse state for one string
    typedef struct packed {
        logic [2:0]  field_index;
        logic        digit_seen;
        logic [8:0]  field_value;
        logic [31:0] address;
        logic        format_error;
    } t_parse_state;

    // one result transaction
    typedef struct packed {
        logic        status;
        logic [31:0] network_address;
        logic [31:0] net_mask;
        logic [5:0]  prefix_length;
    } t_result;

endpackage

/* sv/ipv4pp_step.sv */
// ---------------------------------------------------------------------------
// ipv4pp_step: one-character update of the prefix parser
// Given the current parse state and one text byte, forms the next state and
// the result that an end-of-string byte reports.
// ---------------------------------------------------------------------------
module ipv4pp_step (
    input  ipv4pp_pkg::t_parse_state i_state,
    input  logic [7:0]               i_byte,
    output ipv4pp_pkg::t_parse_state o_next,
    output ipv4pp_pkg::t_result      o_result
);

    logic [12:0] acc;
    logic        octet_ok;
    logic [4:0]  octet_shift;
    logic [31:0] octet_word;
    logic        end_ok;
    logic [5:0]  plen;

    // decimal accumulate; low nibble of '0'..'9' is the digit value
    assign acc = 13'({4'd0, i_state.field_value} * 13'd10) + {9'd0, i_byte[3:0]};

    // octet close conditions and placement in the address
    assign octet_ok    = i_state.digit_seen
                         && (i_state.field_value <= ipv4pp_pkg::OCTET_MAX);
    assign octet_shift = {2'd3 - i_state.field_index[1:0], 3'd0};
    assign octet_word  = {24'd0, i_state.field_value[7:0]} << octet_shift;

    // end-of-string result
    assign end_ok = !i_state.format_error && (i_state.field_index == ipv4pp_pkg::PREFIX_FIELD)
                    && i_state.digit_seen && (i_state.field_value <= ipv4pp_pkg::PREFIX_MAX);
    assign plen   = end_ok ? i_state.field_value[5:0] : 6'd0;

    always_comb begin
        o_result.status          = !end_ok;
        o_result.prefix_length   = plen;
        o_result.network_address = end_ok ? i_state.address : 32'd0;
        o_result.net_mask        = ~(32'hffff_ffff >> plen);
    end

    // next state
    always_comb begin
        o_next = i_state;
        if (i_byte == ipv4pp_pkg::CHAR_NUL) begin
            o_next = '0;
        end else if (!i_state.format_error) begin
            if (i_byte inside {[ipv4pp_pkg::CHAR_ZERO:ipv4pp_pkg::CHAR_NINE]}) begin
                o_next.field_value = (acc > {4'd0, ipv4pp_pkg::ACC_MAX}) ?
                                     ipv4pp_pkg::ACC_MAX : acc[8:0];
                o_next.digit_seen  = 1'b1;
            end else if ((i_byte == ipv4pp_pkg::CHAR_DOT && octet_ok
                          && i_state.field_index < ipv4pp_pkg::LAST_OCTET)
                      || (i_byte == ipv4pp_pkg::CHAR_SLASH && octet_ok
                          && i_state.field_index == ipv4pp_pkg::LAST_OCTET)) begin
                o_next.address     = i_state.address | octet_word;
                o_next.field_index = i_state.field_index + 3'd1;
                o_next.digit_seen  = 1'b0;
                o_next.field_value = 9'd0;
            end else begin
                o_next.format_error = 1'b1;
            end
        end
    end

endmodule

/* sv/ipv4_prefix_text_parser.sv */
// ---------------------------------------------------------------------------
// ipv4_prefix_text_parser: streaming parser for a.b.c.d/n text
// Result: registered when its terminating zero byte is consumed from the input register.
// Throughput: one byte per cycle, but an end byte waits while a pending result is stalled.
// Reset: synchronous, active low; clears the parse state and both valid flags.
// ---------------------------------------------------------------------------
module ipv4_prefix_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [31:0] o_network_address,
    output logic [31:0] o_net_mask,
    output logic [5:0]  o_prefix_length
);

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    ipv4pp_pkg::t_parse_state r_state;
    ipv4pp_pkg::t_parse_state n_state;
    ipv4pp_pkg::t_result      n_result;
    ipv4pp_pkg::t_result      r_result;
    logic                     r_out_valid;
    logic                     out_free;
    logic                     in_is_end;
    logic                     consume;

    // handshake between the input register and the result register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_is_end  = (r_in_byte == ipv4pp_pkg::CHAR_NUL);
    assign consume    = r_in_valid && (!in_is_end || out_free);
    assign o_in_stall = r_in_valid && !consume;

    ipv4pp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_next   (n_state),
        .o_result (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && in_is_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (consume && in_is_end) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_result.status;
    assign o_network_address = r_result.network_address;
    assign o_net_mask        = r_result.net_mask;
    assign o_prefix_length   = r_result.prefix_length;

    // field index never runs past the prefix field
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.field_index <= ipv4pp_pkg::PREFIX_FIELD)
        else $error("field index out of range");

    // an invalid result carries all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |->
        (o_network_address == 32'd0 && o_net_mask == 32'd0 && o_prefix_length == 6'd0))
        else $error("invalid result with nonzero fields");

    // a valid result has a legal prefix length
    a_valid_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |-> (o_prefix_length <= 6'd32))
        else $error("prefix length above 32");

    // end byte clears the parse state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && in_is_end) |=> (r_state == '0 && o_out_valid))
        else $error("state not cleared at end of string");

    // a pending result is never overwritten while stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(consume && in_is_end))
        else $error("result overwritten while stalled");

endmodule
